// ===== design/oaht_pkg.sv =====
// Shared constants, types and the CRC-64 byte step for the open-addressed hash table.
`timescale 1ns / 1ps

package oaht_pkg;

   // Table geometry
   localparam int TABLE_SIZE  = 512;
   localparam int SLOT_W      = $clog2(TABLE_SIZE);
   localparam int HALF_SIZE   = TABLE_SIZE / 2;
   localparam int COUNT_W     = $clog2(HALF_SIZE + 1);
   localparam int VALUE_WIDTH = 32;

   // Field widths
   localparam int KEY_W   = 64;
   localparam int DATA_W  = 32;
   localparam int STAT_W  = 3;
   localparam int LIMIT_W = 10;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

   // Rehash unit
   localparam logic [KEY_W-1:0] CRC_POLY = 64'hC96C5795D7870F42;
   localparam int CRC_BYTES = KEY_W / 8;
   localparam int CRC_CNT_W = $clog2(CRC_BYTES);

   // Request queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Result status codes
   localparam logic [STAT_W-1:0] STAT_OK          = 3'd0;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND   = 3'd1;
   localparam logic [STAT_W-1:0] STAT_DUPLICATE   = 3'd2;
   localparam logic [STAT_W-1:0] STAT_FULL        = 3'd3;
   localparam logic [STAT_W-1:0] STAT_PROBE_LIMIT = 3'd4;

   typedef struct packed {
      logic              insert;
      logic [KEY_W-1:0]  key;
      logic [DATA_W-1:0] value;
      logic [SLOT_W-1:0] first_slot;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   typedef struct packed {
      logic               clearing;
      logic               pop;
      logic [COUNT_W-1:0] entry_count;
   } back_status_type;

   typedef struct packed {
      logic                   occupied;
      logic [KEY_W-1:0]       key;
      logic [VALUE_WIDTH-1:0] value;
   } entry_type;

   // One byte of reflected CRC-64: fold in the byte, then eight bit steps
   function automatic logic [KEY_W-1:0] crc_byte(input logic [KEY_W-1:0] crc,
                                                  input logic [7:0] data);
      logic [KEY_W-1:0] c;
      c = crc ^ {{(KEY_W-8){1'b0}}, data};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== design/oaht_front.sv =====
// Front end: accepts request beats, classifies them and queues them for the probe engine.
`timescale 1ns / 1ps

module oaht_front
   import oaht_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_mode,
   input  logic [KEY_W-1:0]  req_key,
   input  logic [DATA_W-1:0] req_value,
   input  back_status_type   back_status,
   output head_type          head
);

   item_type            queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   item_type            item_in;
   logic                push;
   logic                pop;

   // Hold off requests while the queue is full or the table is being cleared
   assign req_stall = (count_ff == QCNT_W'(QUEUE_DEPTH)) || back_status.clearing;
   assign push      = req_valid && !req_stall;
   assign pop       = back_status.pop;

   // Classify the beat and compute its home slot
   always_comb begin
      item_in.insert     = req_mode;
      item_in.key        = req_key;
      item_in.value      = req_value;
      item_in.first_slot = req_key[SLOT_W-1:0];
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = queue_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the queued beat
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

// ===== design/oaht_back.sv =====
// Back end: probe engine with the slot memory, the rehash unit and the result register.
`timescale 1ns / 1ps

module oaht_back
   import oaht_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data,
   input  head_type           head,
   output back_status_type    back_status,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_found,
   output logic [DATA_W-1:0]  rsp_value_out,
   output logic [SLOT_W-1:0]  rsp_slot,
   output logic [STAT_W-1:0]  rsp_status
);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_CHECK = 2'd2;
   localparam logic [1:0] S_WAIT  = 2'd3;

   entry_type mem [TABLE_SIZE];

   logic [1:0]            state_ff, state_in;
   logic [SLOT_W-1:0]     clear_addr_ff, clear_addr_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [LIMIT_W-1:0]    limit_ff, limit_in;
   logic [LIMIT_W-1:0]    probes_ff, probes_in;
   logic                  crc_run_ff, crc_run_in;
   logic [CRC_CNT_W-1:0]  crc_cnt_ff, crc_cnt_in;
   logic [KEY_W-1:0]      crc_ff, crc_in;
   logic [KEY_W-1:0]      crc_src_ff, crc_src_in;
   logic                  insert_ff;
   logic [KEY_W-1:0]      key_ff;
   logic [VALUE_WIDTH-1:0] value_ff;
   logic [SLOT_W-1:0]     slot_ff;
   entry_type             rd_data_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  found_ff, found_in;
   logic [DATA_W-1:0]     value_out_ff, value_out_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [STAT_W-1:0]     status_ff, status_in;

   logic                  out_free;
   logic [LIMIT_W-1:0]    limit_eff;
   logic                  head_full;
   logic                  pop;
   logic                  occ;
   logic                  hit;
   logic                  at_limit;
   logic                  decide;
   logic                  finish;
   logic                  want_next;
   logic                  issue_next;
   logic [KEY_W-1:0]      next_hash;
   logic                  rd_en;
   logic [SLOT_W-1:0]     rd_addr;
   logic                  wr_en;
   logic [SLOT_W-1:0]     wr_addr;
   entry_type             wr_data;
   logic                  load_full;

   // Decode probe outcome and handshake conditions
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign limit_eff  = (limit_ff == '0) ? LIMIT_W'(1) : limit_ff;
   assign head_full  = head.item.insert && (count_ff >= COUNT_W'(HALF_SIZE));
   assign pop        = (state_ff == S_IDLE) && head.valid && (!head_full || out_free);
   assign load_full  = pop && head_full;
   assign occ        = rd_data_ff.occupied;
   assign hit        = occ && (rd_data_ff.key == key_ff);
   assign at_limit   = probes_ff >= limit_eff;
   assign decide     = (state_ff == S_CHECK) && (!occ || hit || at_limit);
   assign finish     = decide && out_free;
   assign want_next  = ((state_ff == S_CHECK) && !decide) || (state_ff == S_WAIT);
   assign issue_next = want_next && !crc_run_ff;
   assign next_hash  = ~crc_ff;

   // Memory port selection
   assign rd_en   = (pop && !head_full) || issue_next;
   assign rd_addr = issue_next ? next_hash[SLOT_W-1:0] : head.item.first_slot;
   assign wr_en   = (state_ff == S_CLEAR) || (finish && insert_ff && !occ);
   assign wr_addr = (state_ff == S_CLEAR) ? clear_addr_ff : slot_ff;

   always_comb begin
      wr_data = '0;
      if (state_ff != S_CLEAR) begin
         wr_data.occupied = 1'b1;
         wr_data.key      = key_ff;
         wr_data.value    = value_ff;
      end
   end

   // Sequence the clear sweep and probes
   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      case (state_ff)
         S_CLEAR: begin
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == SLOT_W'(TABLE_SIZE - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (pop && !head_full) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (finish) begin
               state_in = S_IDLE;
            end else if (want_next && !issue_next) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (issue_next) begin
               state_in = S_CHECK;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Count entries, probes and take the limit register
   always_comb begin
      count_in  = count_ff;
      probes_in = probes_ff;
      limit_in  = csr_wr_en ? csr_wr_data : limit_ff;
      if (finish && insert_ff && !occ) begin
         count_in = count_ff + 1'b1;
      end
      if (pop) begin
         probes_in = LIMIT_W'(1);
      end else if (issue_next) begin
         probes_in = probes_ff + 1'b1;
      end
   end

   // Restart the rehash on each issued probe, then fold one byte a cycle
   always_comb begin
      crc_run_in = crc_run_ff;
      crc_cnt_in = crc_cnt_ff;
      crc_in     = crc_ff;
      crc_src_in = crc_src_ff;
      if (rd_en) begin
         crc_run_in = 1'b1;
         crc_cnt_in = '0;
         crc_in     = '1;
         crc_src_in = issue_next ? next_hash : head.item.key;
      end else if (crc_run_ff) begin
         crc_in     = crc_byte(crc_ff, crc_src_ff[7:0]);
         crc_src_in = crc_src_ff >> 8;
         crc_cnt_in = crc_cnt_ff + 1'b1;
         if (crc_cnt_ff == CRC_CNT_W'(CRC_BYTES - 1)) begin
            crc_run_in = 1'b0;
         end
      end
   end

   // Build the result beat
   always_comb begin
      rsp_valid_in = rsp_stall ? rsp_valid_ff : 1'b0;
      found_in     = found_ff;
      value_out_in = value_out_ff;
      rsp_slot_in  = rsp_slot_ff;
      status_in    = status_ff;
      if (load_full) begin
         rsp_valid_in = 1'b1;
         found_in     = 1'b0;
         value_out_in = '0;
         rsp_slot_in  = '0;
         status_in    = STAT_FULL;
      end else if (finish) begin
         rsp_valid_in = 1'b1;
         found_in     = !insert_ff && hit;
         value_out_in = (!insert_ff && hit) ? DATA_W'(rd_data_ff.value) : '0;
         rsp_slot_in  = (hit || (!occ && insert_ff)) ? slot_ff : '0;
         if (!occ) begin
            status_in = insert_ff ? STAT_OK : STAT_NOT_FOUND;
         end else if (hit) begin
            status_in = insert_ff ? STAT_DUPLICATE : STAT_OK;
         end else begin
            status_in = STAT_PROBE_LIMIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clear_addr_ff <= '0;
         count_ff      <= '0;
         limit_ff      <= LIMIT_RESET;
         probes_ff     <= '0;
         crc_run_ff    <= 1'b0;
         crc_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         count_ff      <= count_in;
         limit_ff      <= limit_in;
         probes_ff     <= probes_in;
         crc_run_ff    <= crc_run_in;
         crc_cnt_ff    <= crc_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      crc_ff       <= crc_in;
      crc_src_ff   <= crc_src_in;
      found_ff     <= found_in;
      value_out_ff <= value_out_in;
      rsp_slot_ff  <= rsp_slot_in;
      status_ff    <= status_in;
      if (pop) begin
         insert_ff <= head.item.insert;
         key_ff    <= head.item.key;
         value_ff  <= VALUE_WIDTH'(head.item.value);
      end
      if (rd_en) begin
         slot_ff <= rd_addr;
      end
   end

   // Slot memory: one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign back_status.clearing    = (state_ff == S_CLEAR);
   assign back_status.pop         = pop;
   assign back_status.entry_count = count_ff;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = found_ff;
   assign rsp_value_out = value_out_ff;
   assign rsp_slot      = rsp_slot_ff;
   assign rsp_status    = status_ff;

endmodule

// ===== design/open_addressed_hash_table.sv =====
// Top level: open-addressed hash table with CRC-64 rehash on each collision.
// A request is popped and its home slot read into a register, the slot is checked, and the
// result is registered; each further probe first folds the eight rehash bytes, one byte a
// cycle, then reads the slot memory; an insert into a full table answers without a memory read.
// The probe engine holds one request at a time, and a 2-entry queue takes request beats
// while it is busy.
// Reset: synchronous; a clearing pass over the 512 slots empties the memory, with req_stall high.
`timescale 1ns / 1ps

module open_addressed_hash_table
   import oaht_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_mode,
   input  logic [KEY_W-1:0]   req_key,
   input  logic [DATA_W-1:0]  req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_found,
   output logic [DATA_W-1:0]  rsp_value_out,
   output logic [SLOT_W-1:0]  rsp_slot,
   output logic [STAT_W-1:0]  rsp_status
);

   head_type        head;
   back_status_type back_status;

   oaht_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_mode    (req_mode),
      .req_key     (req_key),
      .req_value   (req_value),
      .back_status (back_status),
      .head        (head)
   );

   oaht_back u_back (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .head          (head),
      .back_status   (back_status),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_found     (rsp_found),
      .rsp_value_out (rsp_value_out),
      .rsp_slot      (rsp_slot),
      .rsp_status    (rsp_status)
   );

`ifndef ASSERT_OFF
   // No request beat is taken during the clearing pass
   assert property (@(posedge clock) disable iff (reset)
      back_status.clearing |-> req_stall)
      else $error("request accepted during table clear");

   // Entry count never passes half the table
   assert property (@(posedge clock) disable iff (reset)
      back_status.entry_count <= COUNT_W'(HALF_SIZE))
      else $error("entry count above half capacity");

   // A failed request reports no hit and a zero value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STAT_OK) |-> !rsp_found && (rsp_value_out == '0))
      else $error("hit reported on a failed request");

   // A queue pop only happens when the queue holds a beat
   assert property (@(posedge clock) disable iff (reset)
      back_status.pop |-> head.valid)
      else $error("pop from an empty request queue");
`endif

endmodule
